// ===== hdl/snt_pkg.sv =====
package snt_pkg;

    localparam int FRAC_BITS = 12;
    localparam int ONE = 1 << FRAC_BITS;
    localparam int SIG_RANGE = 8;
    localparam int DEPTH = 256;
    localparam int IDX_BITS = $clog2(DEPTH);
    localparam int IDX_SHIFT = $clog2(SIG_RANGE * ONE) - IDX_BITS;
    localparam int ROM_BITS = FRAC_BITS + 1;
    localparam longint unsigned Q30_ONE = 64'd1 << 30;

    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 24;
    localparam logic [CFG_IDX_BITS-1:0] REG_MODE = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_RATE = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_STEEP = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_THRESH = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_INITW0 = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_INITW1 = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_INITW2 = 3'd6;

    localparam logic [1:0] FUNC_TRAIN = 2'd0;
    localparam logic [1:0] FUNC_EVAL = 2'd1;
    localparam logic [1:0] FUNC_RELOAD = 2'd2;

    localparam logic [23:0] SUM_MAX = 24'hFFFFFF;
    localparam logic [13:0] SERR_MAX = 14'd16383;

    typedef logic [ROM_BITS-1:0] sig_rom_t [DEPTH];

    typedef enum logic [4:0] {
        ST_IDLE, ST_WX0, ST_WX1, ST_WX2, ST_NET, ST_SCALE, ST_LOOKUP, ST_ERR,
        ST_SQ, ST_EK, ST_KG, ST_COEF, ST_W0, ST_W1, ST_W2, ST_WL, ST_FIN
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_WX0, OP_WX1, OP_WX2, OP_NET, OP_SCALE, OP_LOOKUP, OP_ERR,
        OP_SQ, OP_EK, OP_KG, OP_COEF, OP_W0, OP_W1, OP_W2, OP_FIN
    } op_t;

    typedef struct packed {
        logic load;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       out_busy;
    } status_t;

    typedef struct packed {
        logic                     valid;
        logic [CFG_IDX_BITS-1:0]  index;
        logic [CFG_DATA_BITS-1:0] data;
    } cfg_wr_t;

    function automatic longint unsigned udiv(input longint unsigned n,
                                             input longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], n[i]};
            if (r >= d) begin
                r = r - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic sig_rom_t build_sig_rom();
        sig_rom_t rom;
        longint unsigned term;
        longint unsigned acc;
        longint unsigned step;
        longint unsigned e;
        longint unsigned num;
        longint unsigned den;
        longint unsigned q;
        term = Q30_ONE;
        acc = Q30_ONE;
        for (int n = 1; n <= 20; n++) begin
            term = udiv(term * SIG_RANGE, longint'(DEPTH) * longint'(n));
            if (n % 2 == 1) acc = acc - term;
            else acc = acc + term;
        end
        step = acc;
        e = Q30_ONE;
        for (int k = 0; k < DEPTH; k++) begin
            num = 2 * (Q30_ONE - e) * ONE + (Q30_ONE + e);
            den = 2 * (Q30_ONE + e);
            q = udiv(num, den);
            rom[k] = q[ROM_BITS-1:0];
            e = (e * step) >> 30;
        end
        return rom;
    endfunction

    localparam sig_rom_t SIG_ROM = build_sig_rom();

endpackage

// ===== hdl/snt_ctrl.sv =====
module snt_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  snt_pkg::status_t status,
    output snt_pkg::cmd_t    cmd
);
    import snt_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_WX0;
            ST_WX0:    state_next = (status.func == FUNC_RELOAD) ? ST_FIN : ST_WX1;
            ST_WX1:    state_next = ST_WX2;
            ST_WX2:    state_next = ST_NET;
            ST_NET:    state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_LOOKUP;
            ST_LOOKUP: state_next = ST_ERR;
            ST_ERR:    state_next = ST_SQ;
            ST_SQ:     state_next = ST_EK;
            ST_EK:     state_next = (status.func == FUNC_TRAIN) ? ST_KG : ST_FIN;
            ST_KG:     state_next = ST_COEF;
            ST_COEF:   state_next = ST_W0;
            ST_W0:     state_next = ST_W1;
            ST_W1:     state_next = ST_W2;
            ST_W2:     state_next = ST_WL;
            ST_WL:     state_next = ST_FIN;
            ST_FIN:    if (!status.out_busy) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        cmd.load = 1'b0;
        cmd.op = OP_NONE;
        case (state_reg)
            ST_IDLE: begin
                s_tready = aresetn;
                cmd.load = s_tvalid && aresetn;
            end
            ST_WX0:    cmd.op = OP_WX0;
            ST_WX1:    cmd.op = OP_WX1;
            ST_WX2:    cmd.op = OP_WX2;
            ST_NET:    cmd.op = OP_NET;
            ST_SCALE:  cmd.op = OP_SCALE;
            ST_LOOKUP: cmd.op = OP_LOOKUP;
            ST_ERR:    cmd.op = OP_ERR;
            ST_SQ:     cmd.op = OP_SQ;
            ST_EK:     cmd.op = OP_EK;
            ST_KG:     cmd.op = OP_KG;
            ST_COEF:   cmd.op = OP_COEF;
            ST_W0:     cmd.op = OP_W0;
            ST_W1:     cmd.op = OP_W1;
            ST_W2:     cmd.op = OP_W2;
            ST_WL:     cmd.op = OP_NONE;
            ST_FIN:    if (!status.out_busy) cmd.op = OP_FIN;
            default:   cmd.op = OP_NONE;
        endcase
    end

endmodule

// ===== hdl/snt_datapath.sv =====
module snt_datapath (
    input  logic             aclk,
    input  logic             aresetn,
    input  snt_pkg::cfg_wr_t cfg,
    input  logic [63:0]      s_tdata,
    input  logic [1:0]       s_tuser,
    input  logic             s_tlast,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [103:0]     m_tdata,
    output logic             m_tlast,
    input  snt_pkg::cmd_t    cmd,
    output snt_pkg::status_t status
);
    import snt_pkg::*;

    logic               mode_reg;
    logic [12:0]        rate_reg;
    logic [14:0]        steep_reg;
    logic [23:0]        thresh_reg;
    logic signed [15:0] initw_reg [3];

    logic signed [15:0] w_reg [3];
    logic [23:0]        sum_reg;

    logic signed [15:0] x_reg [3];
    logic signed [13:0] d_reg;
    logic [1:0]         func_reg;
    logic               last_reg;

    logic signed [58:0] prod_reg;
    logic signed [33:0] net_reg;
    logic signed [13:0] o_reg;
    logic               cls_reg;
    logic signed [14:0] err_reg;
    logic [12:0]        g_reg;
    logic [13:0]        serr_reg;
    logic signed [27:0] k_reg;
    logic signed [41:0] coef_reg;

    logic signed [41:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [58:0] mul_p;

    logic signed [34:0] z;
    logic [35:0]        z_abs;
    logic [35:0]        idx_full;
    logic [IDX_BITS-1:0] idx;
    logic signed [13:0] rom_val;
    logic [28:0]        sq_round;
    logic signed [21:0] dw;
    logic signed [58:0] r24;
    logic signed [58:0] r37;
    logic signed [22:0] w_sum;
    logic signed [15:0] w_sat;
    logic [1:0]         w_sel;
    logic [24:0]        sum_add;
    logic [23:0]        sum_sat;
    logic               is_train;
    logic [23:0]        ep;
    logic               done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
            rate_reg <= 13'd2048;
            steep_reg <= 15'd4096;
            thresh_reg <= 24'd41;
            for (int i = 0; i < 3; i++) initw_reg[i] <= '0;
        end else if (cfg.valid) begin
            case (cfg.index)
                REG_MODE:   mode_reg <= cfg.data[0];
                REG_RATE:   rate_reg <= cfg.data[12:0];
                REG_STEEP:  steep_reg <= cfg.data[14:0];
                REG_THRESH: thresh_reg <= cfg.data;
                REG_INITW0: initw_reg[0] <= cfg.data[15:0];
                REG_INITW1: initw_reg[1] <= cfg.data[15:0];
                REG_INITW2: initw_reg[2] <= cfg.data[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_WX0: begin
                mul_a = 42'(w_reg[0]);
                mul_b = 17'(x_reg[0]);
            end
            OP_WX1: begin
                mul_a = 42'(w_reg[1]);
                mul_b = 17'(x_reg[1]);
            end
            OP_WX2: begin
                mul_a = 42'(w_reg[2]);
                mul_b = 17'(x_reg[2]);
            end
            OP_SCALE: begin
                mul_a = 42'(net_reg);
                mul_b = {2'b00, steep_reg};
            end
            OP_ERR: begin
                mul_a = 42'(o_reg);
                mul_b = 17'(o_reg);
            end
            OP_SQ: begin
                mul_a = 42'(err_reg);
                mul_b = 17'(err_reg);
            end
            OP_EK: begin
                mul_a = 42'(err_reg);
                mul_b = {4'b0000, rate_reg};
            end
            OP_KG: begin
                mul_a = prod_reg[41:0];
                mul_b = {4'b0000, g_reg};
            end
            OP_W0: begin
                mul_a = coef_reg;
                mul_b = 17'(x_reg[0]);
            end
            OP_W1: begin
                mul_a = coef_reg;
                mul_b = 17'(x_reg[1]);
            end
            OP_W2: begin
                mul_a = coef_reg;
                mul_b = 17'(x_reg[2]);
            end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign z = prod_reg[58:24];
    assign z_abs = z[34] ? -36'(z) : 36'(z);
    assign idx_full = z_abs >> IDX_SHIFT;
    assign idx = (idx_full > 36'(DEPTH - 1)) ? IDX_BITS'(DEPTH - 1) : idx_full[IDX_BITS-1:0];
    assign rom_val = 14'(SIG_ROM[idx]);

    assign sq_round = (prod_reg[28:0] + 29'(ONE)) >> (FRAC_BITS + 1);

    assign r24 = (prod_reg + (59'sd1 <<< 23)) >>> 24;
    assign r37 = (prod_reg + (59'sd1 <<< 36)) >>> 37;
    assign dw = mode_reg ? r24[21:0] : r37[21:0];
    assign w_sel = (cmd.op == OP_W1) ? 2'd0 : (cmd.op == OP_W2) ? 2'd1 : 2'd2;
    assign w_sum = 23'(w_reg[w_sel]) + 23'(dw);
    assign w_sat = (w_sum > 23'sd32767) ? 16'sh7FFF :
                   (w_sum < -23'sd32768) ? -16'sh8000 : w_sum[15:0];

    assign is_train = (func_reg == FUNC_TRAIN);
    assign sum_add = {1'b0, sum_reg} + {11'b0, serr_reg};
    assign sum_sat = sum_add[24] ? SUM_MAX : sum_add[23:0];
    assign ep = is_train ? sum_sat : sum_reg;
    assign done = is_train && last_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg[0] <= s_tdata[15:0];
            x_reg[1] <= s_tdata[31:16];
            x_reg[2] <= s_tdata[47:32];
            d_reg <= s_tdata[61:48];
            func_reg <= s_tuser;
            last_reg <= s_tlast;
        end
        if (cmd.op != OP_NONE) prod_reg <= mul_p;
        case (cmd.op)
            OP_WX1: net_reg <= prod_reg[33:0];
            OP_WX2, OP_NET: net_reg <= net_reg + prod_reg[33:0];
            OP_LOOKUP: begin
                cls_reg <= (net_reg > 34'sd0);
                if (mode_reg) o_reg <= (net_reg > 34'sd0) ? 14'(ONE) : -14'(ONE);
                else o_reg <= z[34] ? -rom_val : rom_val;
            end
            OP_ERR: err_reg <= 15'(d_reg) - 15'(o_reg);
            OP_SQ: g_reg <= 13'(ONE) - prod_reg[24:12];
            OP_EK: serr_reg <= (sq_round > 29'(SERR_MAX)) ? SERR_MAX : sq_round[13:0];
            OP_KG: k_reg <= prod_reg[27:0];
            OP_COEF: coef_reg <= mode_reg ? 42'(k_reg) : prod_reg[41:0];
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) w_reg[i] <= '0;
            sum_reg <= '0;
        end else begin
            case (cmd.op)
                OP_W1, OP_W2: w_reg[w_sel] <= w_sat;
                OP_FIN: begin
                    if (func_reg == FUNC_RELOAD) begin
                        for (int i = 0; i < 3; i++) w_reg[i] <= initw_reg[i];
                        sum_reg <= '0;
                    end else if (done) begin
                        sum_reg <= '0;
                    end else if (is_train) begin
                        sum_reg <= sum_sat;
                    end
                end
                default: ;
            endcase
            if (cmd.op == OP_FIN && is_train) w_reg[2] <= w_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (cmd.op == OP_FIN) begin
            m_tvalid <= 1'b1;
        end else if (m_tready) begin
            m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_FIN) begin
            if (func_reg == FUNC_RELOAD) begin
                m_tdata <= {2'b00, initw_reg[2], initw_reg[1], initw_reg[0], 54'd0};
                m_tlast <= 1'b0;
            end else begin
                m_tdata <= {2'b00, is_train ? w_sat : w_reg[2], w_reg[1], w_reg[0],
                            done && (ep <= thresh_reg), ep, serr_reg, cls_reg, o_reg};
                m_tlast <= done;
            end
        end
    end

    assign status.func = func_reg;
    assign status.out_busy = m_tvalid && !m_tready;

endmodule

// ===== hdl/single_neuron_trainer_core.sv =====
// One item at a time: the next input transfer is taken only after the result of
// the last has been issued. Train runs every step, evaluate stops after the error
// terms, reload loads the initial weights and goes straight to the result, which
// waits while the result channel is stalled. One shared 42x17 multiplier.
// Reset (aresetn low, synchronous): registers to defaults, weights and epoch sum
// to zero, both channels empty.
module single_neuron_trainer_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [snt_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [snt_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [63:0]                   s_tdata,  // x0, x1, x2, target, pad
    input  logic [1:0]                    s_tuser,  // func
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [103:0]                  m_tdata,  // neuron_output, class_positive,
                                                    // sample_error, epoch_error,
                                                    // converged, weight_out0..2, pad
    output logic                          m_tlast
);
    import snt_pkg::*;

    cmd_t    cmd;
    status_t status;
    cfg_wr_t cfg;

    assign cfg_ready = aresetn;
    assign cfg.valid = cfg_valid;
    assign cfg.index = cfg_index;
    assign cfg.data = cfg_data;

    snt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    snt_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

// ===== hdl/snt_checker.sv =====
module snt_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         cfg_ready,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata,
    input logic         m_tlast
);

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in work");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    a_conv_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[53] |-> m_tlast)
        else $error("converged outside epoch end");

    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("config channel stalled");

endmodule

bind single_neuron_trainer_core snt_checker u_snt_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_ready (cfg_ready),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
);
